FILE: rtl/tlptw_pkg.sv
`default_nettype none

package tlptw_pkg;

    // item field widths
    localparam int VPN_W        = 20;
    localparam int PPN_W        = 20;
    localparam int IDX_W        = 10;
    localparam int ENTRY_W      = PPN_W + 1;
    localparam int ENTRIES_PER_NODE = 1024;

    // configuration port
    localparam int ROOT_FRAME_W = 4;
    localparam int FIRST_FREE_W = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int ROOT_TBL_N   = 1 << ROOT_FRAME_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'd1;

    localparam logic [FIRST_FREE_W-1:0] FIRST_FREE_RST = 5'd1;

    // request codes
    localparam logic REQ_QUERY  = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // frame store geometry default
    localparam int FRAMES_DEF = 16;

    // remainder unit: digits retired per cycle
    localparam int REM_DIGITS = 4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT,
        S_MOD,
        S_LEAF_WR,
        S_FIN
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic take;
        logic alloc;
        logic set_nf;
        logic rem_start;
        logic leaf_rd;
        logic leaf_wr;
        logic use_rem;
        logic out_load;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic root_valid;
        logic is_query;
        logic is_unmap;
        logic pool_empty;
        logic rem_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/tlptw_rem.sv
`default_nettype none

module tlptw_rem #(
    parameter int FRAMES = tlptw_pkg::FRAMES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [tlptw_pkg::PPN_W-1:0]  i_value,
    output logic                              o_done,
    output logic [$clog2(FRAMES)-1:0]         o_rem
);

    localparam int R_W = $clog2(FRAMES);
    localparam int T_W = R_W + 1;
    localparam int V_W = tlptw_pkg::PPN_W;
    localparam int DIG = tlptw_pkg::REM_DIGITS;
    localparam int NSTEP = (V_W + DIG - 1) / DIG;
    localparam int CNT_W = $clog2(NSTEP + 1);
    localparam int PAD_W = NSTEP * DIG;
    localparam logic [T_W-1:0] FR_T = T_W'(FRAMES);

    generate
        if ((FRAMES & (FRAMES - 1)) == 0) begin : g_pow2
            // power of two: remainder is the low bits
            logic [R_W-1:0] r_rem;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_rem <= '0;
                end else if (i_start) begin
                    r_rem <= i_value[R_W-1:0];
                end
            end

            assign o_rem  = r_rem;
            assign o_done = 1'b1;
        end else begin : g_serial
            // restoring remainder, REM_DIGITS bits per cycle from the top
            logic [PAD_W-1:0] r_val;
            logic [R_W-1:0]   r_rem;
            logic [R_W-1:0]   n_rem;
            logic [CNT_W-1:0] r_cnt;

            always_comb begin
                logic [T_W-1:0] t;
                n_rem = r_rem;
                for (int k = 0; k < DIG; k++) begin
                    t = {n_rem, r_val[PAD_W-1-k]};
                    if (t >= FR_T) begin
                        t = t - FR_T;
                    end
                    n_rem = t[R_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt <= '0;
                end else if (i_start) begin
                    r_cnt <= CNT_W'(NSTEP);
                end else if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val <= PAD_W'(i_value);
                    r_rem <= '0;
                end else if (r_cnt != '0) begin
                    r_val <= r_val << DIG;
                    r_rem <= n_rem;
                end
            end

            assign o_rem  = r_rem;
            assign o_done = (r_cnt == '0);
        end
    endgenerate

endmodule

`default_nettype wire

FILE: rtl/tlptw_ctrl.sv
`default_nettype none

module tlptw_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire tlptw_pkg::t_dp_sts i_sts,
    output tlptw_pkg::t_dp_cmd      o_cmd,
    output logic                    o_in_stall
);

    tlptw_pkg::t_state r_state;
    tlptw_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlptw_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlptw_pkg::S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = tlptw_pkg::S_IDLE;
                end
            end
            tlptw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tlptw_pkg::S_ROOT;
                end
            end
            tlptw_pkg::S_ROOT: begin
                if (i_sts.root_valid) begin
                    n_state = tlptw_pkg::S_MOD;
                end else if (i_sts.is_query || i_sts.is_unmap || i_sts.pool_empty) begin
                    n_state = tlptw_pkg::S_FIN;
                end else begin
                    n_state = tlptw_pkg::S_LEAF_WR;
                end
            end
            tlptw_pkg::S_MOD: begin
                if (i_sts.rem_done) begin
                    n_state = tlptw_pkg::S_FIN;
                end
            end
            tlptw_pkg::S_LEAF_WR: begin
                n_state = tlptw_pkg::S_FIN;
            end
            tlptw_pkg::S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = tlptw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlptw_pkg::S_CLEAR;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            tlptw_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            tlptw_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
            end
            tlptw_pkg::S_ROOT: begin
                if (i_sts.root_valid) begin
                    o_cmd.rem_start = 1'b1;
                end else if (!i_sts.is_query && !i_sts.is_unmap) begin
                    o_cmd.set_nf = i_sts.pool_empty;
                    o_cmd.alloc  = !i_sts.pool_empty;
                end
            end
            tlptw_pkg::S_MOD: begin
                o_cmd.use_rem = 1'b1;
                o_cmd.leaf_rd = i_sts.rem_done && i_sts.is_query;
                o_cmd.leaf_wr = i_sts.rem_done && !i_sts.is_query;
            end
            tlptw_pkg::S_LEAF_WR: begin
                o_cmd.leaf_wr = 1'b1;
            end
            tlptw_pkg::S_FIN: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/tlptw_dp.sv
`default_nettype none

module tlptw_dp #(
    parameter int FRAMES = tlptw_pkg::FRAMES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tlptw_pkg::t_dp_cmd                i_cmd,
    output tlptw_pkg::t_dp_sts                     o_sts,
    input  wire logic                              i_cfg_we,
    input  wire logic [tlptw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tlptw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                              i_req_type,
    input  wire logic [tlptw_pkg::VPN_W-1:0]       i_vpn,
    input  wire logic [tlptw_pkg::PPN_W-1:0]       i_new_ppn,
    input  wire logic                              i_unmap,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output logic                                   o_mapped,
    output logic [tlptw_pkg::PPN_W-1:0]            o_ppn_out,
    output logic                                   o_no_frame
);

    localparam int FIDX_W  = $clog2(FRAMES);
    localparam int IDX_W   = tlptw_pkg::IDX_W;
    localparam int ADDR_W  = FIDX_W + IDX_W;
    localparam int DEPTH   = FRAMES * tlptw_pkg::ENTRIES_PER_NODE;
    localparam int NF_MIN  = $clog2(FRAMES + 1);
    localparam int NF_W    = (NF_MIN > tlptw_pkg::FIRST_FREE_W) ? NF_MIN
                                                                : tlptw_pkg::FIRST_FREE_W;
    localparam int ENTRY_W = tlptw_pkg::ENTRY_W;
    localparam int PPN_W   = tlptw_pkg::PPN_W;
    localparam int VPN_W   = tlptw_pkg::VPN_W;

    // frame store
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_we;
    logic               mem_re;

    // configuration and allocator
    logic [tlptw_pkg::ROOT_FRAME_W-1:0] r_root_frame;
    logic [NF_W-1:0]                    r_next_free;
    logic [FIDX_W-1:0]                  root_tbl [tlptw_pkg::ROOT_TBL_N];
    logic [FIDX_W-1:0]                  root_idx;

    // item registers
    logic               r_req;
    logic [VPN_W-1:0]   r_vpn;
    logic [PPN_W-1:0]   r_ppn;
    logic               r_unmap;
    logic [FIDX_W-1:0]  r_leaf_frame;
    logic [FIDX_W-1:0]  leaf_frame;
    logic               r_rd_leaf;
    logic               r_nf;
    logic [ADDR_W-1:0]  r_clr_addr;

    // remainder unit
    logic               rem_done;
    logic [FIDX_W-1:0]  rem_val;

    // result
    logic               res_mapped;

    // root frame taken modulo the frame count
    for (genvar g = 0; g < tlptw_pkg::ROOT_TBL_N; g++) begin : g_root_tbl
        assign root_tbl[g] = FIDX_W'(g % FRAMES);
    end
    assign root_idx = root_tbl[r_root_frame];

    tlptw_rem #(
        .FRAMES (FRAMES)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.rem_start),
        .i_value (r_rd_data[PPN_W-1:0]),
        .o_done  (rem_done),
        .o_rem   (rem_val)
    );

    assign leaf_frame = i_cmd.use_rem ? rem_val : r_leaf_frame;

    // frame store address and data selection
    always_comb begin
        mem_addr  = r_clr_addr;
        mem_wdata = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        if (i_cmd.clr_wr) begin
            mem_we = 1'b1;
        end else if (i_cmd.take) begin
            mem_re   = 1'b1;
            mem_addr = {root_idx, i_vpn[VPN_W-1:IDX_W]};
        end else if (i_cmd.alloc) begin
            mem_we    = 1'b1;
            mem_addr  = {root_idx, r_vpn[VPN_W-1:IDX_W]};
            mem_wdata = {1'b1, PPN_W'(r_next_free)};
        end else if (i_cmd.leaf_rd) begin
            mem_re   = 1'b1;
            mem_addr = {leaf_frame, r_vpn[IDX_W-1:0]};
        end else if (i_cmd.leaf_wr) begin
            mem_we    = 1'b1;
            mem_addr  = {leaf_frame, r_vpn[IDX_W-1:0]};
            mem_wdata = r_unmap ? '0 : {1'b1, r_ppn};
        end
    end

    // single-port store with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end else if (mem_re) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // configuration registers and bump allocator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_frame <= '0;
            r_next_free  <= NF_W'(tlptw_pkg::FIRST_FREE_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlptw_pkg::CFG_ROOT_FRAME: begin
                    r_root_frame <= i_cfg_data[tlptw_pkg::ROOT_FRAME_W-1:0];
                end
                tlptw_pkg::CFG_FIRST_FREE: begin
                    r_next_free <= NF_W'(i_cfg_data);
                end
                default: begin
                    r_root_frame <= r_root_frame;
                end
            endcase
        end else if (i_cmd.alloc) begin
            r_next_free <= r_next_free + 1'b1;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req   <= i_req_type;
            r_vpn   <= i_vpn;
            r_ppn   <= i_new_ppn;
            r_unmap <= i_unmap;
        end
        if (i_cmd.alloc) begin
            r_leaf_frame <= r_next_free[FIDX_W-1:0];
        end
    end

    // per-item result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_leaf <= 1'b0;
            r_nf      <= 1'b0;
        end else if (i_cmd.take) begin
            r_rd_leaf <= 1'b0;
            r_nf      <= 1'b0;
        end else begin
            if (i_cmd.leaf_rd) begin
                r_rd_leaf <= 1'b1;
            end
            if (i_cmd.set_nf) begin
                r_nf <= 1'b1;
            end
        end
    end

    assign res_mapped = r_rd_leaf && r_rd_data[ENTRY_W-1];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_mapped   <= res_mapped;
            o_ppn_out  <= res_mapped ? r_rd_data[PPN_W-1:0] : '0;
            o_no_frame <= r_nf;
        end
    end

    // status back to the controller
    always_comb begin
        o_sts.clr_last   = (r_clr_addr == ADDR_W'(DEPTH - 1));
        o_sts.root_valid = r_rd_data[ENTRY_W-1];
        o_sts.is_query   = (r_req == tlptw_pkg::REQ_QUERY);
        o_sts.is_unmap   = r_unmap;
        o_sts.pool_empty = (r_next_free >= NF_W'(FRAMES));
        o_sts.rem_done   = rem_done;
        o_sts.out_free   = !o_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

FILE: rtl/two_level_page_table_walker.sv
`default_nettype none

// channel   direction  handshake                 payload
// request   in         i_in_valid / o_in_stall   i_req_type, i_vpn, i_new_ppn, i_unmap
// result    out        o_out_valid / i_out_stall o_mapped, o_ppn_out, o_no_frame
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// an item with a leaf access steps through root read, root check or allocation,
// leaf read or write, and result load; without a leaf access it skips the leaf
// step. the single-port frame store sets these steps. when FRAMES is not a power
// of two, items whose root entry is valid first wait on the leaf pointer remainder.
// after reset all FRAMES*1024 store entries are swept to zero with the input stalled;
// configuration writes are taken throughout. a new item is taken while a result waits.

module two_level_page_table_walker #(
    parameter int FRAMES = tlptw_pkg::FRAMES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tlptw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tlptw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_req_type,
    input  wire logic [tlptw_pkg::VPN_W-1:0]       i_vpn,
    input  wire logic [tlptw_pkg::PPN_W-1:0]       i_new_ppn,
    input  wire logic                              i_unmap,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_mapped,
    output logic [tlptw_pkg::PPN_W-1:0]            o_ppn_out,
    output logic                                   o_no_frame
);

    tlptw_pkg::t_dp_cmd cmd;
    tlptw_pkg::t_dp_sts sts;

    tlptw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    tlptw_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_req_type),
        .i_vpn       (i_vpn),
        .i_new_ppn   (i_new_ppn),
        .i_unmap     (i_unmap),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_mapped    (o_mapped),
        .o_ppn_out   (o_ppn_out),
        .o_no_frame  (o_no_frame)
    );

endmodule

`default_nettype wire
